FILE: hdl/lcdp_pkg.sv
// shared types, constants and activation table functions of the lstm cell predictor
`timescale 1ns / 1ps

package lcdp_pkg;

    // default sizes
    localparam int HIDDEN_UNITS_DEF = 16;
    localparam int ACT_ENTRIES_DEF  = 256;

    // activation table word, covers [-4096, 4096]
    localparam int TAB_W = 14;

    // command codes
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    // kind of term in a gate sum
    typedef enum logic [1:0] {
        TERM_IN,
        TERM_REC,
        TERM_BIAS
    } term_t;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_MAC,
        S_MDRAIN1,
        S_MDRAIN2,
        S_GIDX,
        S_GROM,
        S_GSAVE,
        S_CREAD,
        S_CMUL1,
        S_CMUL2,
        S_CDRAIN,
        S_CRND,
        S_CROM,
        S_HMUL,
        S_HDRAIN,
        S_HRND,
        S_DMUL,
        S_FDRAIN,
        S_FOUT
    } state_t;

    // restoring long division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // e^(a/4096) in q20: series for a/8 then squared three times
    function automatic logic [63:0] exp_q20(input logic [63:0] a);
        logic [63:0] f;
        logic [63:0] sum;
        logic [63:0] term;
        logic [63:0] x;
        f = a << 5;
        sum = 64'd1 << 20;
        term = 64'd1 << 20;
        for (int n = 1; n <= 14; n++)
        begin
            term = udiv64((term * f) >> 20, 64'(n));
            sum = sum + term;
        end
        x = sum;
        for (int n = 0; n < 3; n++)
        begin
            x = (x * x) >> 20;
        end
        return x;
    endfunction

    // sigmoid of a q3.12 value
    function automatic logic signed [TAB_W-1:0] sig_eval(input longint t);
        logic [63:0] a;
        logic [63:0] e;
        logic [63:0] d;
        logic [63:0] s;
        a = (t < 0) ? 64'(-t) : 64'(t);
        e = exp_q20(a);
        d = e + (64'd1 << 20);
        s = udiv64(e * 64'd4096 + (d >> 1), d);
        if (t < 0)
        begin
            s = 64'd4096 - s;
        end
        return TAB_W'(s);
    endfunction

    // tanh of a q3.12 value
    function automatic logic signed [TAB_W-1:0] tanh_eval(input longint t);
        logic [63:0] a;
        logic [63:0] e;
        logic [63:0] e2;
        logic [63:0] d;
        logic [63:0] r;
        a = (t < 0) ? 64'(-t) : 64'(t);
        e = exp_q20(a);
        e2 = (e * e) >> 20;
        d = e2 + (64'd1 << 20);
        r = udiv64((e2 - (64'd1 << 20)) * 64'd4096 + (d >> 1), d);
        if (t < 0)
        begin
            r = -r;
        end
        return TAB_W'(r);
    endfunction

    // midpoint of table segment i out of n
    function automatic longint entry_mid(input longint i, input longint n);
        longint m;
        m = longint'(udiv64(64'((2 * i + 1) * 32768), 64'(n))) - 32768;
        if (m > 32767)
        begin
            m = 32767;
        end
        return m;
    endfunction

endpackage

FILE: hdl/lcdp_act_rom.sv
// sigmoid and tanh lookup tables with registered read
`timescale 1ns / 1ps

module lcdp_act_rom #(
    parameter int ENTRIES = lcdp_pkg::ACT_ENTRIES_DEF,
    parameter int IDX_W   = $clog2(ENTRIES)
) (
    input  logic                                clk,
    input  logic [IDX_W-1:0]                    idx,
    output logic signed [lcdp_pkg::TAB_W-1:0]  sig_q,
    output logic signed [lcdp_pkg::TAB_W-1:0]  tanh_q
);

    typedef logic signed [lcdp_pkg::TAB_W-1:0] tab_t [ENTRIES];

    // fill one table at elaboration
    function automatic tab_t build_tab(input logic use_tanh);
        tab_t   tab;
        longint mid;
        for (int i = 0; i < ENTRIES; i++)
        begin
            mid = lcdp_pkg::entry_mid(longint'(i), longint'(ENTRIES));
            tab[i] = use_tanh ? lcdp_pkg::tanh_eval(mid) : lcdp_pkg::sig_eval(mid);
        end
        return tab;
    endfunction

    localparam tab_t SIG_TAB  = build_tab(1'b0);
    localparam tab_t TANH_TAB = build_tab(1'b1);

    // registered table reads
    always_ff @(posedge clk)
    begin
        sig_q  <= SIG_TAB[idx];
        tanh_q <= TANH_TAB[idx];
    end

endmodule

FILE: hdl/lstm_cell_dense_predictor.sv
// top level: lstm cell with dense output neuron, weight and state memories, sequencer
`timescale 1ns / 1ps

// One LSTM cell with a scalar Q3.12 input and a dense output neuron. A weight
// write (cmd 0) or a state clear (cmd 2) takes effect as it is accepted. For a
// sample (cmd 1), every product goes through one shared 16x16 multiplier fed
// by the single read port of the weight memory, one gate sum of H + 2 terms
// at a time, each followed by rounding and a table lookup, then a cell,
// hidden and dense update per unit. Hidden and cell state sit in a two-bank
// state memory, so the old hidden vector stays readable while the new one is
// written; the banks swap when the prediction is loaded for output. Items
// are taken one at a time; a waiting prediction holds back only the end of
// the next one.
module lstm_cell_dense_predictor #(
    parameter int HIDDEN_UNITS      = lcdp_pkg::HIDDEN_UNITS_DEF,
    parameter int ACT_TABLE_ENTRIES = lcdp_pkg::ACT_ENTRIES_DEF,
    parameter int WADDR_W = $clog2(9 * HIDDEN_UNITS + 4 * HIDDEN_UNITS * HIDDEN_UNITS)
) (
    input  logic                clk,
    input  logic                rst_n,
    // input channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          cmd,
    input  logic [WADDR_W-1:0]  weight_addr,
    input  logic signed [15:0]  weight_value,
    input  logic signed [15:0]  sample,
    // output channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  prediction,
    output logic                saturated,
    // configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int H         = HIDDEN_UNITS;
    localparam int UW        = (H > 1) ? $clog2(H) : 1;
    localparam int KW        = $clog2(H + 2);
    localparam int OFS_REC   = 4 * H;
    localparam int OFS_BIAS  = OFS_REC + 4 * H * H;
    localparam int OFS_DENSE = OFS_BIAS + 4 * H;
    localparam int DEPTH     = OFS_DENSE + H;
    localparam int SDEPTH    = 2 ** (UW + 1);
    localparam int ACC_W     = 32 + $clog2(H + 2);
    localparam int IDX_W     = $clog2(ACT_TABLE_ENTRIES);
    localparam int TW        = lcdp_pkg::TAB_W;

    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2048);
    localparam logic signed [ACC_W-1:0] Q_MAX    = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Q_MIN    = -ACC_W'(32768);

    // round half up to q3.12 and saturate, flag in the top bit
    function automatic logic [16:0] rnd_sat(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        logic [16:0]             r;
        t = a + RND_HALF;
        t = t >>> 12;
        if (t > Q_MAX)
        begin
            r = {1'b1, 16'h7fff};
        end
        else if (t < Q_MIN)
        begin
            r = {1'b1, 16'h8000};
        end
        else
        begin
            r = {1'b0, t[15:0]};
        end
        return r;
    endfunction

    // table entry for a q3.12 value
    function automatic logic [IDX_W-1:0] act_index(input logic [15:0] v);
        logic [15:0]       off;
        logic [IDX_W+15:0] p;
        off = {~v[15], v[14:0]};
        p = (IDX_W + 16)'(off) * (IDX_W + 16)'(ACT_TABLE_ENTRIES);
        return p[IDX_W+15:16];
    endfunction

    lcdp_pkg::state_t state_reg, state_next;

    logic [UW-1:0]           u_reg;
    logic [1:0]              g_reg;
    logic [KW-1:0]           k_reg;
    logic                    bank_reg;
    logic signed [15:0]      x_reg;
    logic signed [15:0]      bias_reg;
    logic                    sat_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] dacc_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic signed [TW-1:0]    gv_reg [4];
    logic signed [15:0]      c_new_reg;
    logic signed [15:0]      h_new_reg;
    logic signed [15:0]      wd_reg;
    logic                    out_valid_reg;
    logic signed [15:0]      pred_reg;
    logic                    psat_reg;

    // issue pipeline of the gate sum
    logic                    iss_v_reg;
    logic                    iss_first_reg;
    lcdp_pkg::term_t         iss_kind_reg;

    // multiplier stage
    logic                    mul_en;
    logic                    mul_first;
    logic                    mul_dense;
    logic signed [15:0]      mul_a;
    logic signed [15:0]      mul_b;
    logic signed [31:0]      prod_reg;
    logic                    prod_v_reg;
    logic                    prod_first_reg;
    logic                    prod_dense_reg;
    logic signed [ACC_W-1:0] prod_ext;

    // memories
    logic [15:0]             weight_mem [DEPTH];
    logic [31:0]             state_mem [SDEPTH];
    logic                    state_vld_reg [SDEPTH];
    logic [WADDR_W-1:0]      w_raddr;
    logic signed [15:0]      w_rd_reg;
    logic                    w_we;
    logic [UW:0]             st_raddr;
    logic [31:0]             st_rd_reg;
    logic                    st_vld_rd_reg;
    logic                    st_we;
    logic [UW:0]             st_waddr;

    logic                    in_acc;
    logic                    out_free;
    logic                    last_unit;
    logic [KW-1:0]           k_last;
    logic [16:0]             acc_rnd;
    logic [16:0]             dacc_rnd;
    logic [WADDR_W-1:0]      gu;
    logic signed [15:0]      h_old;
    logic signed [15:0]      c_old;
    logic signed [TW-1:0]    sig_q;
    logic signed [TW-1:0]    tanh_q;
    logic                    cfg_wr;

    assign in_ready  = (state_reg == lcdp_pkg::S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign last_unit = (u_reg == UW'(H - 1));
    assign k_last    = KW'(H + 1);
    assign acc_rnd   = rnd_sat(acc_reg);
    assign dacc_rnd  = rnd_sat(dacc_reg);
    assign gu        = WADDR_W'(g_reg) * WADDR_W'(H) + WADDR_W'(u_reg);
    assign h_old     = st_vld_rd_reg ? $signed(st_rd_reg[31:16]) : 16'sd0;
    assign c_old     = st_vld_rd_reg ? $signed(st_rd_reg[15:0]) : 16'sd0;
    assign prod_ext  = {{(ACC_W - 32){prod_reg[31]}}, prod_reg};

    // activation tables
    lcdp_act_rom #(
        .ENTRIES (ACT_TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_act_rom (
        .clk    (clk),
        .idx    (idx_reg),
        .sig_q  (sig_q),
        .tanh_q (tanh_q)
    );

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{16{bias_reg[15]}}, bias_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bias_reg <= '0;
        end
        else if (cfg_wr && paddr[2] == 1'b0)
        begin
            bias_reg <= $signed(pwdata[15:0]);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lcdp_pkg::S_IDLE:
            begin
                if (in_acc && cmd == lcdp_pkg::CMD_SAMPLE)
                begin
                    state_next = lcdp_pkg::S_MAC;
                end
            end
            lcdp_pkg::S_MAC:
            begin
                if (k_reg == k_last)
                begin
                    state_next = lcdp_pkg::S_MDRAIN1;
                end
            end
            lcdp_pkg::S_MDRAIN1: state_next = lcdp_pkg::S_MDRAIN2;
            lcdp_pkg::S_MDRAIN2: state_next = lcdp_pkg::S_GIDX;
            lcdp_pkg::S_GIDX:    state_next = lcdp_pkg::S_GROM;
            lcdp_pkg::S_GROM:    state_next = lcdp_pkg::S_GSAVE;
            lcdp_pkg::S_GSAVE:
            begin
                state_next = (g_reg == 2'd3) ? lcdp_pkg::S_CREAD : lcdp_pkg::S_MAC;
            end
            lcdp_pkg::S_CREAD:   state_next = lcdp_pkg::S_CMUL1;
            lcdp_pkg::S_CMUL1:   state_next = lcdp_pkg::S_CMUL2;
            lcdp_pkg::S_CMUL2:   state_next = lcdp_pkg::S_CDRAIN;
            lcdp_pkg::S_CDRAIN:  state_next = lcdp_pkg::S_CRND;
            lcdp_pkg::S_CRND:    state_next = lcdp_pkg::S_CROM;
            lcdp_pkg::S_CROM:    state_next = lcdp_pkg::S_HMUL;
            lcdp_pkg::S_HMUL:    state_next = lcdp_pkg::S_HDRAIN;
            lcdp_pkg::S_HDRAIN:  state_next = lcdp_pkg::S_HRND;
            lcdp_pkg::S_HRND:    state_next = lcdp_pkg::S_DMUL;
            lcdp_pkg::S_DMUL:
            begin
                state_next = last_unit ? lcdp_pkg::S_FDRAIN : lcdp_pkg::S_MAC;
            end
            lcdp_pkg::S_FDRAIN:  state_next = lcdp_pkg::S_FOUT;
            lcdp_pkg::S_FOUT:
            begin
                if (out_free)
                begin
                    state_next = lcdp_pkg::S_IDLE;
                end
            end
            default:             state_next = lcdp_pkg::S_IDLE;
        endcase
    end

    // memory addresses and multiplier operands
    always_comb
    begin
        w_raddr   = WADDR_W'(OFS_DENSE) + WADDR_W'(u_reg);
        st_raddr  = {bank_reg, u_reg};
        w_we      = 1'b0;
        st_we     = 1'b0;
        st_waddr  = {~bank_reg, u_reg};
        mul_en    = 1'b0;
        mul_first = 1'b0;
        mul_dense = 1'b0;
        mul_a     = w_rd_reg;
        mul_b     = x_reg;
        case (state_reg)
            lcdp_pkg::S_IDLE:
            begin
                w_we = in_acc && cmd == lcdp_pkg::CMD_WRITE
                       && ({1'b0, weight_addr} < (WADDR_W + 1)'(DEPTH));
            end
            lcdp_pkg::S_MAC:
            begin
                if (k_reg == '0)
                begin
                    w_raddr = gu;
                end
                else if (k_reg == k_last)
                begin
                    w_raddr = WADDR_W'(OFS_BIAS) + gu;
                end
                else
                begin
                    w_raddr = WADDR_W'(OFS_REC) + gu * WADDR_W'(H)
                              + WADDR_W'(k_reg) - WADDR_W'(1);
                end
                st_raddr = {bank_reg, k_reg[UW-1:0] - UW'(1)};
            end
            lcdp_pkg::S_CMUL1:
            begin
                mul_en    = 1'b1;
                mul_first = 1'b1;
                mul_a     = {{(16 - TW){gv_reg[1][TW-1]}}, gv_reg[1]};
                mul_b     = c_old;
            end
            lcdp_pkg::S_CMUL2:
            begin
                mul_en = 1'b1;
                mul_a  = {{(16 - TW){gv_reg[0][TW-1]}}, gv_reg[0]};
                mul_b  = {{(16 - TW){gv_reg[2][TW-1]}}, gv_reg[2]};
            end
            lcdp_pkg::S_HMUL:
            begin
                mul_en    = 1'b1;
                mul_first = 1'b1;
                mul_a     = {{(16 - TW){gv_reg[3][TW-1]}}, gv_reg[3]};
                mul_b     = {{(16 - TW){tanh_q[TW-1]}}, tanh_q};
            end
            lcdp_pkg::S_HRND:
            begin
                st_we = 1'b1;
            end
            lcdp_pkg::S_DMUL:
            begin
                mul_en    = 1'b1;
                mul_dense = 1'b1;
                mul_a     = h_new_reg;
                mul_b     = wd_reg;
            end
            default:
            begin
            end
        endcase
        // gate sum terms come in the cycle after their read
        if (iss_v_reg)
        begin
            mul_en    = 1'b1;
            mul_first = iss_first_reg;
            mul_a     = w_rd_reg;
            case (iss_kind_reg)
                lcdp_pkg::TERM_IN:   mul_b = x_reg;
                lcdp_pkg::TERM_REC:  mul_b = h_old;
                lcdp_pkg::TERM_BIAS: mul_b = 16'sd4096;
                default:             mul_b = x_reg;
            endcase
        end
    end

    // weight memory
    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            weight_mem[weight_addr] <= weight_value;
        end
        w_rd_reg <= $signed(weight_mem[w_raddr]);
    end

    // state memory, two banks of {hidden, cell}
    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            state_mem[st_waddr] <= {acc_rnd[15:0], c_new_reg};
        end
        st_rd_reg <= state_mem[st_raddr];
    end

    // state entry valid bits, an invalid entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SDEPTH; i++)
            begin
                state_vld_reg[i] <= 1'b0;
            end
            st_vld_rd_reg <= 1'b0;
        end
        else
        begin
            st_vld_rd_reg <= state_vld_reg[st_raddr];
            if (in_acc && cmd == lcdp_pkg::CMD_CLEAR)
            begin
                for (int i = 0; i < SDEPTH; i++)
                begin
                    state_vld_reg[i] <= 1'b0;
                end
            end
            else if (st_we)
            begin
                state_vld_reg[st_waddr] <= 1'b1;
            end
        end
    end

    // multiplier and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg       <= mul_a * mul_b;
        prod_first_reg <= mul_first;
        prod_dense_reg <= mul_dense;
        if (in_acc)
        begin
            dacc_reg <= {{(ACC_W - 28){bias_reg[15]}}, bias_reg, 12'd0};
        end
        else if (prod_v_reg && prod_dense_reg)
        begin
            dacc_reg <= dacc_reg + prod_ext;
        end
        if (prod_v_reg && !prod_dense_reg)
        begin
            acc_reg <= prod_first_reg ? prod_ext : acc_reg + prod_ext;
        end
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcdp_pkg::S_IDLE;
            u_reg         <= '0;
            g_reg         <= '0;
            k_reg         <= '0;
            bank_reg      <= 1'b0;
            sat_reg       <= 1'b0;
            iss_v_reg     <= 1'b0;
            iss_first_reg <= 1'b0;
            iss_kind_reg  <= lcdp_pkg::TERM_IN;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_v_reg     <= (state_reg == lcdp_pkg::S_MAC);
            iss_first_reg <= (k_reg == '0);
            if (k_reg == '0)
            begin
                iss_kind_reg <= lcdp_pkg::TERM_IN;
            end
            else if (k_reg == k_last)
            begin
                iss_kind_reg <= lcdp_pkg::TERM_BIAS;
            end
            else
            begin
                iss_kind_reg <= lcdp_pkg::TERM_REC;
            end
            // result register and bank swap as the prediction is loaded for output
            if (state_reg == lcdp_pkg::S_FOUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                bank_reg      <= ~bank_reg;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                lcdp_pkg::S_IDLE:
                begin
                    u_reg   <= '0;
                    g_reg   <= '0;
                    k_reg   <= '0;
                    sat_reg <= 1'b0;
                end
                lcdp_pkg::S_MAC:
                begin
                    k_reg <= k_reg + KW'(1);
                end
                lcdp_pkg::S_GIDX:
                begin
                    sat_reg <= sat_reg | acc_rnd[16];
                end
                lcdp_pkg::S_GSAVE:
                begin
                    g_reg <= g_reg + 2'd1;
                    k_reg <= '0;
                end
                lcdp_pkg::S_CRND:
                begin
                    sat_reg <= sat_reg | acc_rnd[16];
                end
                lcdp_pkg::S_DMUL:
                begin
                    u_reg <= u_reg + UW'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers of the sequencer
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg <= sample;
        end
        case (state_reg)
            lcdp_pkg::S_GIDX:
            begin
                idx_reg <= act_index(acc_rnd[15:0]);
            end
            lcdp_pkg::S_GSAVE:
            begin
                gv_reg[g_reg] <= (g_reg == 2'd2) ? tanh_q : sig_q;
            end
            lcdp_pkg::S_CMUL1:
            begin
                wd_reg <= w_rd_reg;
            end
            lcdp_pkg::S_CRND:
            begin
                c_new_reg <= $signed(acc_rnd[15:0]);
                idx_reg   <= act_index(acc_rnd[15:0]);
            end
            lcdp_pkg::S_HRND:
            begin
                h_new_reg <= $signed(acc_rnd[15:0]);
            end
            lcdp_pkg::S_FOUT:
            begin
                if (out_free)
                begin
                    pred_reg <= $signed(dacc_rnd[15:0]);
                    psat_reg <= sat_reg | dacc_rnd[16];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign prediction = pred_reg;
    assign saturated  = psat_reg;

    // new state never lands in the bank being read
    a_bank_split: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> st_waddr[UW] != bank_reg)
        else $error("state write into active bank");

    // term counter stays inside one gate sum
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lcdp_pkg::S_MAC |-> k_reg <= k_last)
        else $error("gate term counter out of range");

    // banks swap exactly when a prediction is loaded for output
    a_bank_swap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lcdp_pkg::S_FOUT && out_free) |=> bank_reg != $past(bank_reg))
        else $error("banks did not swap");

    // a result appears only from the final step
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == lcdp_pkg::S_FOUT)
        else $error("result raised outside final step");

endmodule

FILE: tb/sv/lstm_cell_dense_predictor_test.sv
// self-checking testbench of the lstm cell predictor with its own fixed-point model
`timescale 1ns / 1ps

module lstm_cell_dense_predictor_test;

    localparam int H           = 16;
    localparam int OFS_IN      = 0;
    localparam int OFS_REC     = 4 * H;
    localparam int OFS_BIAS    = OFS_REC + 4 * H * H;
    localparam int OFS_DENSE   = OFS_BIAS + 4 * H;
    localparam int STORE_DEPTH = OFS_DENSE + H;
    localparam int ENTRIES     = 256;
    localparam int WATCHDOG    = 20000;
    localparam int RANDOM_ITEMS = 750;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [2:0] REG_OUT_BIAS = 3'd0;
    localparam longint unsigned ONE_Q20 = 64'd1 << 20;

    typedef struct {
        logic [1:0]         cmd;
        logic [10:0]        addr;
        logic signed [15:0] wval;
        logic signed [15:0] smp;
        bit                 typed;
        logic signed [15:0] t_pred;
        bit                 t_sat;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [1:0] cmd = '0;
    logic [10:0] weight_addr = '0;
    logic signed [15:0] weight_value = '0;
    logic signed [15:0] sample = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [15:0] prediction;
    logic saturated;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    // model state
    logic signed [15:0] weight_mem [STORE_DEPTH];
    int hidden_vec [H];
    int cell_vec [H];
    int sig_lut [ENTRIES];
    int tanh_lut [ENTRIES];
    int bias_copy;

    // expected predictions in order
    logic signed [15:0] expected_prediction_q [$];
    bit expected_saturated_q [$];
    stim_row_t dir_rows [$];

    int fail_count = 0;
    int idle_cycles = 0;
    bit tx_quiet = 1'b0;

    lstm_cell_dense_predictor dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .weight_addr(weight_addr), .weight_value(weight_value), .sample(sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .prediction(prediction), .saturated(saturated),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 clk = ~clk;

    // e^(a/4096) in q20
    function automatic longint unsigned exp_fix(longint unsigned a);
        longint unsigned f;
        longint unsigned acc;
        longint unsigned term;
        f = a << 5;
        acc = ONE_Q20;
        term = ONE_Q20;
        for (int n = 1; n <= 14; n++)
        begin
            term = ((term * f) >> 20) / longint'(n);
            acc = acc + term;
        end
        for (int n = 0; n < 3; n++)
        begin
            acc = (acc * acc) >> 20;
        end
        return acc;
    endfunction

    function automatic int sigmoid_fix(int t);
        longint unsigned e;
        longint unsigned d;
        int s;
        e = exp_fix((t < 0) ? -t : t);
        d = e + ONE_Q20;
        s = int'((e * 4096 + d / 2) / d);
        return (t < 0) ? 4096 - s : s;
    endfunction

    function automatic int tanh_fix(int t);
        longint unsigned e;
        longint unsigned e2;
        longint unsigned d;
        int r;
        e = exp_fix((t < 0) ? -t : t);
        e2 = (e * e) >> 20;
        d = e2 + ONE_Q20;
        r = int'(((e2 - ONE_Q20) * 4096 + d / 2) / d);
        return (t < 0) ? -r : r;
    endfunction

    // q?.24 to q3.12, round half up, clamp and flag
    function automatic int round_clamp(longint acc, inout bit flag);
        longint r;
        r = (acc + 2048) >>> 12;
        if (r > 32767)
        begin
            r = 32767;
            flag = 1'b1;
        end
        if (r < -32768)
        begin
            r = -32768;
            flag = 1'b1;
        end
        return int'(r);
    endfunction

    function automatic int lut_index(int x);
        return (x + 32768) >>> 8;
    endfunction

    // one lstm step over the model state
    task automatic compute_prediction(input logic signed [15:0] x, output logic signed [15:0] p,
                                      output bit sat);
        int gate [4][H];
        int new_h [H];
        longint acc;
        int s;
        bit dummy;
        sat = 1'b0;
        for (int g = 0; g < 4; g++)
        begin
            for (int u = 0; u < H; u++)
            begin
                acc = longint'(weight_mem[OFS_IN + g * H + u]) * longint'(x);
                for (int j = 0; j < H; j++)
                begin
                    acc += longint'(weight_mem[OFS_REC + (g * H + u) * H + j])
                           * longint'(hidden_vec[j]);
                end
                acc += longint'(weight_mem[OFS_BIAS + g * H + u]) * 4096;
                s = round_clamp(acc, sat);
                gate[g][u] = (g == 2) ? tanh_lut[lut_index(s)] : sig_lut[lut_index(s)];
            end
        end
        for (int u = 0; u < H; u++)
        begin
            dummy = 1'b0;
            acc = longint'(gate[1][u]) * cell_vec[u] + longint'(gate[0][u]) * gate[2][u];
            cell_vec[u] = round_clamp(acc, sat);
            new_h[u] = round_clamp(longint'(gate[3][u]) * tanh_lut[lut_index(cell_vec[u])],
                                   dummy);
        end
        acc = longint'(bias_copy) * 4096;
        for (int u = 0; u < H; u++)
        begin
            hidden_vec[u] = new_h[u];
            acc += longint'(new_h[u]) * longint'(weight_mem[OFS_DENSE + u]);
        end
        p = 16'(round_clamp(acc, sat));
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // drive one transaction, update the model on acceptance
    task automatic send_item(input stim_row_t row);
        logic signed [15:0] p;
        bit sat;
        int gap;
        in_valid <= 1'b1;
        cmd <= row.cmd;
        weight_addr <= row.addr;
        weight_value <= row.wval;
        sample <= row.smp;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        case (row.cmd)
            lcdp_pkg::CMD_WRITE:
            begin
                if (row.addr < STORE_DEPTH)
                begin
                    weight_mem[row.addr] = row.wval;
                end
            end
            lcdp_pkg::CMD_CLEAR:
            begin
                for (int u = 0; u < H; u++)
                begin
                    hidden_vec[u] = 0;
                    cell_vec[u] = 0;
                end
            end
            lcdp_pkg::CMD_SAMPLE:
            begin
                compute_prediction(row.smp, p, sat);
                expected_prediction_q.push_back(row.typed ? row.t_pred : p);
                expected_saturated_q.push_back(row.typed ? row.t_sat : sat);
            end
            default:
            begin
            end
        endcase
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // let the block drain, then write the output bias
    task automatic set_out_bias(input logic signed [15:0] value);
        in_valid <= 1'b0;
        while (expected_prediction_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_OUT_BIAS;
        pwdata <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        bias_copy = value;
    endtask

    function automatic stim_row_t make_row(logic [1:0] c, int a, int w, int s);
        stim_row_t r;
        r.cmd = c;
        r.addr = 11'(a);
        r.wval = 16'(w);
        r.smp = 16'(s);
        r.typed = 1'b0;
        r.t_pred = '0;
        r.t_sat = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(int s, int p, bit sat);
        stim_row_t r;
        r = make_row(lcdp_pkg::CMD_SAMPLE, 0, 0, s);
        r.typed = 1'b1;
        r.t_pred = 16'(p);
        r.t_sat = sat;
        return r;
    endfunction

    function automatic stim_row_t random_row();
        int r;
        r = $urandom_range(0, 99);
        if (r < 42)
        begin
            return make_row(lcdp_pkg::CMD_WRITE, $urandom_range(0, STORE_DEPTH - 1),
                            ($urandom_range(0, 3) == 0) ? $urandom() :
                            $urandom_range(0, 4095) - 2048, $urandom());
        end
        if (r < 47)
        begin
            return make_row(lcdp_pkg::CMD_WRITE, $urandom_range(0, 2047), $urandom(),
                            $urandom());
        end
        if (r < 52)
        begin
            return make_row(lcdp_pkg::CMD_CLEAR, $urandom(), $urandom(), $urandom());
        end
        if (r < 56)
        begin
            return make_row(CMD_UNUSED, $urandom(), $urandom(), $urandom());
        end
        return make_row(lcdp_pkg::CMD_SAMPLE, $urandom(), $urandom(),
                        ($urandom_range(0, 1) == 0) ? $urandom() : $urandom_range(0, 8191) - 4096);
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_prediction_q.size() == 0)
            begin
                $error("unexpected transaction: prediction %0d saturated %0b",
                       prediction, saturated);
                fail_count++;
            end
            else
            begin
                if (prediction !== expected_prediction_q[0])
                begin
                    $error("prediction expected %0d actual %0d",
                           expected_prediction_q[0], prediction);
                    fail_count++;
                end
                if (saturated !== expected_saturated_q[0])
                begin
                    $error("saturated expected %0b actual %0b",
                           expected_saturated_q[0], saturated);
                    fail_count++;
                end
                void'(expected_prediction_q.pop_front());
                void'(expected_saturated_q.pop_front());
            end
        end
    end

    // receiver stalls
    int stall_left = 0;
    int rx_count = 0;
    always @(posedge clk)
    begin
        rx_count <= rx_count + 1;
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end
        else if ((rx_count / 3000) % 4 == 3)
        begin
            out_ready <= 1'b1;
        end
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3: stall_left <= $urandom_range(1, 3);
                4:          stall_left <= $urandom_range(10, 40);
                default:    stall_left <= 0;
            endcase
            out_ready <= ($urandom_range(0, 1) == 1);
        end
    end

    // watchdog on progress
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            sig_lut[i] = sigmoid_fix((2 * i + 1) * 128 - 32768);
            tanh_lut[i] = tanh_fix((2 * i + 1) * 128 - 32768);
        end
        for (int u = 0; u < H; u++)
        begin
            hidden_vec[u] = 0;
            cell_vec[u] = 0;
        end
        bias_copy = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_out_bias(16'sd1024);
        // zero store: every prediction is the output bias
        for (int a = 0; a < STORE_DEPTH; a++)
        begin
            send_item(make_row(lcdp_pkg::CMD_WRITE, a, 0, 0));
        end

        dir_rows.push_back(typed_row(0, 1024, 1'b0));
        dir_rows.push_back(typed_row(32767, 1024, 1'b0));
        dir_rows.push_back(typed_row(-32768, 1024, 1'b0));
        dir_rows.push_back(make_row(CMD_UNUSED, 2047, -1, -1));
        dir_rows.push_back(make_row(lcdp_pkg::CMD_CLEAR, 0, 0, 0));
        // writes past the end of the store
        dir_rows.push_back(make_row(lcdp_pkg::CMD_WRITE, STORE_DEPTH, 32767, 0));
        dir_rows.push_back(make_row(lcdp_pkg::CMD_WRITE, 2047, -32768, 0));
        dir_rows.push_back(typed_row(100, 1024, 1'b0));
        // input weight at full scale saturates the gate sum
        dir_rows.push_back(make_row(lcdp_pkg::CMD_WRITE, OFS_IN, 32767, 0));
        dir_rows.push_back(typed_row(32767, 1024, 1'b1));
        dir_rows.push_back(typed_row(-32768, 1024, 1'b1));
        dir_rows.push_back(make_row(lcdp_pkg::CMD_WRITE, OFS_DENSE, -32768, 0));
        dir_rows.push_back(make_row(lcdp_pkg::CMD_SAMPLE, 0, 0, 32767));
        dir_rows.push_back(make_row(lcdp_pkg::CMD_WRITE, OFS_BIAS + 5, 32767, 0));
        dir_rows.push_back(make_row(lcdp_pkg::CMD_WRITE, OFS_REC + 37, -32768, 0));
        dir_rows.push_back(make_row(lcdp_pkg::CMD_SAMPLE, 0, 0, -1));
        dir_rows.push_back(make_row(lcdp_pkg::CMD_WRITE, OFS_DENSE + H - 1, 32767, 0));
        dir_rows.push_back(make_row(lcdp_pkg::CMD_SAMPLE, 0, 0, 12345));
        dir_rows.push_back(make_row(lcdp_pkg::CMD_CLEAR, 2047, -1, -1));
        dir_rows.push_back(make_row(lcdp_pkg::CMD_SAMPLE, 0, 0, 0));
        foreach (dir_rows[i])
        begin
            send_item(dir_rows[i]);
        end

        // random weights across the whole store
        for (int a = 0; a < STORE_DEPTH; a++)
        begin
            send_item(make_row(lcdp_pkg::CMD_WRITE, a,
                               ($urandom_range(0, 15) == 0) ? $urandom() :
                               $urandom_range(0, 2047) - 1024, 0));
        end

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                case ((n / 150) % 5)
                    0: set_out_bias(16'sd32767);
                    1: set_out_bias(-16'sd32768);
                    2: set_out_bias(16'sd0);
                    default: set_out_bias(16'($urandom()));
                endcase
            end
            tx_quiet = ((n / 100) % 4) == 2;
            send_item(random_row());
        end

        in_valid <= 1'b0;
        while (expected_prediction_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/lcdp_pkg.sv
hdl/lcdp_act_rom.sv
hdl/lstm_cell_dense_predictor.sv
tb/sv/lstm_cell_dense_predictor_test.sv
